>>> hdl/ctb_pkg.sv
// Shared types and codes for the block cache tag engine.
// No dependencies; used by the top level module.
package ctb_pkg;

    typedef enum logic [1:0] {
        MODE_LOOKUP  = 2'd0,
        MODE_RESERVE = 2'd1,
        MODE_COMMIT  = 2'd2,
        MODE_FLUSH   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REASON_NONE     = 2'd0,
        REASON_SNAPSHOT = 2'd1,
        REASON_PAGE     = 2'd2,
        REASON_STALE    = 2'd3
    } reason_t;

    localparam int SLOTS   = 64;
    localparam int CFG_W   = 7;
    localparam int PADDR_W = 3;

    // Key and epoch stamp of one slot, kept together in the tag memory.
    typedef struct packed {
        logic [31:0] tablespace_id;
        logic [31:0] database_id;
        logic [31:0] relation_id;
        logic [1:0]  fork_number;
        logic [31:0] block_number;
        logic [63:0] snapshot_scn;
        logic [63:0] page_lsn;
        logic [63:0] epoch;
    } tag_t;

endpackage

>>> hdl/ctb_if.sv
// Valid/ready channel interfaces for items in and results out.
// No dependencies.
interface ctb_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] tablespace_id;
    logic [31:0] database_id;
    logic [31:0] relation_id;
    logic [1:0]  fork_number;
    logic [31:0] block_number;
    logic [63:0] snapshot_scn;
    logic [63:0] page_lsn;
    logic [63:0] epoch;
    logic [63:0] relation_gen;

    modport source (output valid, mode, tablespace_id, database_id, relation_id,
                    fork_number, block_number, snapshot_scn, page_lsn, epoch,
                    relation_gen, input ready);
    modport sink (input valid, mode, tablespace_id, database_id, relation_id,
                  fork_number, block_number, snapshot_scn, page_lsn, epoch,
                  relation_gen, output ready);
endinterface

interface ctb_result_if #(parameter int CNT_W = 7);
    logic             valid;
    logic             ready;
    logic             hit;
    logic [CNT_W-1:0] slot;
    logic [1:0]       miss_reason;
    logic             evicted;
    logic [CNT_W-1:0] live_count;

    modport source (output valid, hit, slot, miss_reason, evicted, live_count,
                    input ready);
    modport sink (input valid, hit, slot, miss_reason, evicted, live_count,
                  output ready);
endinterface

>>> hdl/ctb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/clock_block_cache_tags_top.sv
// Top level of the block cache tag and clock replacement engine.
// Depends on ctb_pkg, ctb_if.sv (ctb_item_if, ctb_result_if) and ctb_ram.
//
//  channel   dir  kind           payload
//  req       in   valid/ready    mode, key fields, epoch, relation_gen
//  rsp       out  valid/ready    hit, slot, miss_reason, evicted, live_count
//  apb       in   APB write/read active_slots at byte address 0
//
// One item at a time. Lookup reads one tag memory entry per slot, pipelined
// against the compare, ends early on a hit or stale match, and compares no
// entry with caching disabled. Reserve scans for the lowest free slot and, if
// none is free, runs the clock sweep. Commit and flush go straight to result.
// Reset clears valid and second-chance bits, hand, pending slot and count;
// tag memories need no clearing. A full output register holds the engine in
// its result state; req is taken again as soon as the engine is idle.
module clock_block_cache_tags_top (
    input  logic                       clk,
    input  logic                       rst_n,
    ctb_item_if.sink                   req,
    ctb_result_if.source               rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ctb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    localparam int SLOTS = ctb_pkg::SLOTS;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TAG_W = $bits(ctb_pkg::tag_t);
    localparam logic [CW-1:0] NONE = CW'(SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOKUP, ST_FREE, ST_SWEEP, ST_WRITE, ST_COMMIT, ST_FLUSH, ST_RESULT
    } state_t;

    // Clamp a register value to the slot count.
    function automatic logic [CW-1:0] eff_slots(input logic [ctb_pkg::CFG_W-1:0] v);
        logic [CW-1:0] r;
        if (int'(v) > SLOTS)
        begin
            r = NONE;
        end
        else
        begin
            r = CW'(v);
        end
        return r;
    endfunction

    state_t                     state_reg;
    logic [ctb_pkg::CFG_W-1:0]  active_reg;
    logic [SLOTS-1:0]           valid_reg;
    logic [SLOTS-1:0]           sc_reg;
    logic [IW-1:0]              hand_reg;
    logic [CW-1:0]              pending_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              rd_idx_reg;
    logic [IW-1:0]              cmp_idx_reg;
    logic                       cmp_vld_reg;
    logic [IW-1:0]              victim_reg;
    logic                       ev_reg;
    logic                       res_hit_reg;
    logic [CW-1:0]              res_slot_reg;
    logic [1:0]                 res_reason_reg;
    ctb_pkg::tag_t              key_reg;
    logic [63:0]                gen_reg;

    logic                       rsp_valid_reg;
    logic                       rsp_hit_reg;
    logic [CW-1:0]              rsp_slot_reg;
    logic [1:0]                 rsp_reason_reg;
    logic                       rsp_ev_reg;
    logic [CW-1:0]              rsp_live_reg;

    logic [CW-1:0]              cap;
    logic                       cfg_we;
    logic                       out_free;
    ctb_pkg::tag_t              tag_rd;
    ctb_pkg::tag_t              tag_wd;
    logic [63:0]                gen_rd;
    logic                       gen_we;
    logic [IW-1:0]              gen_waddr;
    logic [63:0]                gen_wd;
    logic                       same_block;
    logic                       full_match;
    logic                       fresh;
    logic                       ent_live;
    logic [CW-1:0]              hand_next;
    logic                       commit_ok;

    assign cap      = eff_slots(active_reg);
    assign pready   = 1'b1;
    assign prdata   = {{(32 - ctb_pkg::CFG_W){1'b0}}, active_reg};
    assign cfg_we   = psel && penable && pwrite && !paddr[2];
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_hit_reg;
    assign rsp.slot        = rsp_slot_reg;
    assign rsp.miss_reason = rsp_reason_reg;
    assign rsp.evicted     = rsp_ev_reg;
    assign rsp.live_count  = rsp_live_reg;

    // Key fields and epoch stamp live in one memory, generation in another so
    // commit can write it without touching the key.
    assign tag_wd    = key_reg;
    assign commit_ok = (pending_reg < cap);
    assign gen_we    = (state_reg == ST_WRITE) || ((state_reg == ST_COMMIT) && commit_ok);
    assign gen_waddr = (state_reg == ST_WRITE) ? victim_reg : pending_reg[IW-1:0];
    assign gen_wd    = (state_reg == ST_WRITE) ? 64'd0 : gen_reg;

    ctb_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
        .clk   (clk),
        .we    (state_reg == ST_WRITE),
        .waddr (victim_reg),
        .wdata (tag_wd),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (tag_rd)
    );

    ctb_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wd),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (gen_rd)
    );

    // Compare stage for the entry read last cycle.
    assign same_block = (tag_rd.tablespace_id == key_reg.tablespace_id)
                     && (tag_rd.database_id == key_reg.database_id)
                     && (tag_rd.relation_id == key_reg.relation_id)
                     && (tag_rd.fork_number == key_reg.fork_number)
                     && (tag_rd.block_number == key_reg.block_number);
    assign full_match = same_block && (tag_rd.snapshot_scn == key_reg.snapshot_scn)
                     && (tag_rd.page_lsn == key_reg.page_lsn);
    assign fresh      = (tag_rd.epoch == key_reg.epoch) && (gen_rd == gen_reg);
    assign ent_live   = cmp_vld_reg && valid_reg[cmp_idx_reg];

    // Hand advance wraps at the active slot count.
    assign hand_next = ((CW'(hand_reg) + CW'(1)) == cap) ? '0 : (CW'(hand_reg) + CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= ctb_pkg::CFG_W'(64);
            valid_reg      <= '0;
            sc_reg         <= '0;
            hand_reg       <= '0;
            pending_reg    <= NONE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless a new one loads this cycle.
            if (rsp_valid_reg && rsp.ready && (state_reg != ST_RESULT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            // Config must be written only while idle (a rule for the user; the block does
            // not enforce it); a change of slot count drops every entry.
            if (cfg_we)
            begin
                active_reg <= pwdata[ctb_pkg::CFG_W-1:0];
                if (eff_slots(pwdata[ctb_pkg::CFG_W-1:0]) != cap)
                begin
                    valid_reg   <= '0;
                    sc_reg      <= '0;
                    hand_reg    <= '0;
                    pending_reg <= NONE;
                    count_reg   <= '0;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        key_reg.tablespace_id <= req.tablespace_id;
                        key_reg.database_id   <= req.database_id;
                        key_reg.relation_id   <= req.relation_id;
                        key_reg.fork_number   <= req.fork_number;
                        key_reg.block_number  <= req.block_number;
                        key_reg.snapshot_scn  <= req.snapshot_scn;
                        key_reg.page_lsn      <= req.page_lsn;
                        key_reg.epoch         <= req.epoch;
                        gen_reg               <= req.relation_gen;
                        res_hit_reg           <= 1'b0;
                        res_slot_reg          <= NONE;
                        res_reason_reg        <= ctb_pkg::REASON_NONE;
                        ev_reg                <= 1'b0;
                        rd_idx_reg            <= '0;
                        cmp_vld_reg           <= 1'b0;
                        unique case (ctb_pkg::mode_t'(req.mode))
                            ctb_pkg::MODE_LOOKUP:  state_reg <= ST_LOOKUP;
                            ctb_pkg::MODE_RESERVE: state_reg <= ST_FREE;
                            ctb_pkg::MODE_COMMIT:  state_reg <= ST_COMMIT;
                            ctb_pkg::MODE_FLUSH:   state_reg <= ST_FLUSH;
                            default:               state_reg <= ST_FLUSH;
                        endcase
                    end
                end

                ST_LOOKUP:
                begin
                    // Issue the next read while the previous entry compares;
                    // stop comparing once an exact match ends the scan.
                    cmp_vld_reg <= (rd_idx_reg < cap) && !(ent_live && full_match);
                    cmp_idx_reg <= rd_idx_reg[IW-1:0];
                    if (rd_idx_reg < cap)
                    begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                    end
                    if (ent_live && full_match)
                    begin
                        // Exact match ends the scan either way.
                        if (fresh)
                        begin
                            sc_reg[cmp_idx_reg] <= 1'b1;
                            res_hit_reg         <= 1'b1;
                            res_slot_reg        <= CW'(cmp_idx_reg);
                            res_reason_reg      <= ctb_pkg::REASON_NONE;
                        end
                        else
                        begin
                            res_reason_reg <= ctb_pkg::REASON_STALE;
                        end
                        state_reg   <= ST_RESULT;
                    end
                    else
                    begin
                        if (ent_live && same_block && (res_reason_reg != ctb_pkg::REASON_PAGE))
                        begin
                            if (tag_rd.snapshot_scn == key_reg.snapshot_scn)
                            begin
                                res_reason_reg <= ctb_pkg::REASON_PAGE;
                            end
                            else if (res_reason_reg == ctb_pkg::REASON_NONE)
                            begin
                                res_reason_reg <= ctb_pkg::REASON_SNAPSHOT;
                            end
                        end
                        if (!cmp_vld_reg && (rd_idx_reg >= cap))
                        begin
                            state_reg <= ST_RESULT;
                        end
                    end
                end

                ST_FREE:
                begin
                    // Walk valid bits for the lowest free slot.
                    priority if (cap == '0)
                    begin
                        pending_reg <= NONE;
                        state_reg   <= ST_RESULT;
                    end
                    else if (rd_idx_reg >= cap)
                    begin
                        if (CW'(hand_reg) >= cap)
                        begin
                            hand_reg <= '0;
                        end
                        state_reg <= ST_SWEEP;
                    end
                    else if (!valid_reg[rd_idx_reg[IW-1:0]])
                    begin
                        victim_reg <= rd_idx_reg[IW-1:0];
                        ev_reg     <= 1'b0;
                        state_reg  <= ST_WRITE;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                    end
                end

                ST_SWEEP:
                begin
                    // Clear second chance or take the slot under the hand.
                    hand_reg <= hand_next[IW-1:0];
                    if (sc_reg[hand_reg])
                    begin
                        sc_reg[hand_reg] <= 1'b0;
                    end
                    else
                    begin
                        victim_reg <= hand_reg;
                        ev_reg     <= 1'b1;
                        state_reg  <= ST_WRITE;
                    end
                end

                ST_WRITE:
                begin
                    if (valid_reg[victim_reg])
                    begin
                        valid_reg[victim_reg] <= 1'b0;
                        count_reg             <= count_reg - CW'(1);
                    end
                    sc_reg[victim_reg] <= 1'b0;
                    pending_reg        <= CW'(victim_reg);
                    res_slot_reg       <= CW'(victim_reg);
                    state_reg          <= ST_RESULT;
                end

                ST_COMMIT:
                begin
                    if (commit_ok)
                    begin
                        if (!valid_reg[pending_reg[IW-1:0]])
                        begin
                            valid_reg[pending_reg[IW-1:0]] <= 1'b1;
                            count_reg                      <= count_reg + CW'(1);
                        end
                        res_slot_reg <= pending_reg;
                    end
                    pending_reg <= NONE;
                    state_reg   <= ST_RESULT;
                end

                ST_FLUSH:
                begin
                    valid_reg   <= '0;
                    sc_reg      <= '0;
                    hand_reg    <= '0;
                    pending_reg <= NONE;
                    count_reg   <= '0;
                    state_reg   <= ST_RESULT;
                end

                ST_RESULT:
                begin
                    // Hold until the output register can take the transfer.
                    if (out_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_hit_reg    <= res_hit_reg;
                        rsp_slot_reg   <= res_slot_reg;
                        rsp_reason_reg <= res_reason_reg;
                        rsp_ev_reg     <= ev_reg;
                        rsp_live_reg   <= count_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Live count tracks the valid bits exactly.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(valid_reg))
        else $error("live count out of step with valid bits");

    // A reserved slot stays invalid until its commit.
    a_pending_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == NONE) || !valid_reg[pending_reg[IW-1:0]])
        else $error("pending slot is already valid");

    // A hit result names a slot inside the table.
    a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) && rsp_hit_reg |-> (rsp_slot_reg < NONE))
        else $error("hit reported without a slot");
endmodule
